[src/mpa_pkg.sv]
// ----------------------------------------------------------------------------
// mpa_pkg: shared types and constants of the Metropolis accept/anneal core
// Action codes, register indexes, chain memory word and the exp(-x) table.
// ----------------------------------------------------------------------------
package mpa_pkg;

   localparam int CHAINS_DEFAULT = 8;
   localparam int WINDOW_DEFAULT = 256;

   localparam logic [31:0] START_VALUE  = 32'd655360000;   // 10000.0 in Q16.16
   localparam logic [31:0] TEMP_RESET   = 32'd65536;
   localparam logic [31:0] SCALE_RESET  = 32'd65536;
   localparam logic [15:0] TARGET_RESET = 16'd16384;
   localparam logic [15:0] BAND_RESET   = 16'd3277;

   localparam int EXP_BITS = 20;    // bits of x below 16.0

   typedef enum logic [1:0] {
      ACT_TRIAL  = 2'd0,
      ACT_ANNEAL = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_INIT_TEMP = 2'd0,
      REG_SCALE     = 2'd1,
      REG_TARGET    = 2'd2,
      REG_BAND      = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [31:0] last_value;
      logic [31:0] accepts;
      logic [31:0] trials;
   } chain_word_type;

   typedef struct packed {
      logic rd;
      logic wr;
      logic clr;
   } mem_ctl_type;

   localparam chain_word_type CHAIN_RESET = '{START_VALUE, 32'd0, 32'd0};

   // exp(-2^(b-16)) in Q0.32
   function automatic logic [31:0] exp_bit(input logic [4:0] b);
      logic [31:0] v;
      case (b)
         5'd0:  v = 32'd4294901760;
         5'd1:  v = 32'd4294836226;
         5'd2:  v = 32'd4294705160;
         5'd3:  v = 32'd4294443040;
         5'd4:  v = 32'd4293918848;
         5'd5:  v = 32'd4292870656;
         5'd6:  v = 32'd4290775039;
         5'd7:  v = 32'd4286586875;
         5'd8:  v = 32'd4278222805;
         5'd9:  v = 32'd4261543595;
         5'd10: v = 32'd4228380000;
         5'd11: v = 32'd4162825044;
         5'd12: v = 32'd4034748382;
         5'd13: v = 32'd3790295335;
         5'd14: v = 32'd3344923893;
         5'd15: v = 32'd2605029347;
         5'd16: v = 32'd1580030169;
         5'd17: v = 32'd581260615;
         5'd18: v = 32'd78665070;
         5'd19: v = 32'd1440801;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

[src/metropolis_accept_anneal_core.sv]
// ----------------------------------------------------------------------------
// metropolis_accept_anneal_core: Metropolis acceptance test with annealing
// Trials, anneals and clears over per-chain state in memory, one at a time.
// ----------------------------------------------------------------------------
// One item is worked at a time. A trial goes from the read to the check and
// on to the update when downhill or out of reach, straight to the finish
// when the chain is out of range, and through a 20-step restoring divide for
// x, 20 exp table steps (one bit of x per cycle) and the probability compare
// when uphill. An anneal takes $clog2(WINDOW+1)+16 divide steps for the
// window rate, then the band test, and a temperature update when out of
// band; an empty window goes straight to the finish. Clear and no-op go from
// the read to the finish. A stalled response holds the core until the output
// register is free. The next item is taken as soon as the result is in the
// output register. Chain state sits in a one-port memory with valid bits, the
// accept window in a bit memory read at the head; no clearing pass is needed.
// ----------------------------------------------------------------------------
module metropolis_accept_anneal_core #(
   parameter int CHAINS = mpa_pkg::CHAINS_DEFAULT,
   parameter int WINDOW = mpa_pkg::WINDOW_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [2:0]         req_chain,
   input  logic signed [31:0] req_trial_value,
   input  logic [15:0]        req_random_fraction,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic               rsp_annealed,
   output logic [31:0]        rsp_accept_count,
   output logic [31:0]        rsp_trial_count,
   output logic [31:0]        rsp_temperature_now,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);
   import mpa_pkg::*;

   localparam int AW    = (CHAINS > 1) ? $clog2(CHAINS) : 1;
   localparam int HW    = $clog2(WINDOW);
   localparam int FW    = $clog2(WINDOW + 1);
   localparam int NW    = FW + 16;                      // rate numerator bits
   localparam int CNT_W = $clog2((NW > EXP_BITS ? NW : EXP_BITS) + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CHECK, S_DIV, S_EXP, S_PROB, S_UPDATE,
      S_RDIV, S_ANN, S_ANN2, S_FINISH
   } state_type;

   state_type state_ff;

   // configuration
   logic [31:0] scale_ff, temp_ff;
   logic [15:0] target_ff, band_ff;

   // item
   action_type         act_ff;
   logic               chain_ok_ff;
   logic [AW-1:0]      idx_ff;
   logic signed [31:0] trial_ff;
   logic [15:0]        rnd_ff;

   // datapath
   logic signed [32:0] d_ff;
   logic [63:0]        p_ff;
   logic [63:0]        rem_ff;
   logic [19:0]        quot_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [4:0]         expb_ff;
   logic [32:0]        acc_ff;
   logic               ok_ff, ann_ff;
   logic [31:0]        cnt_acc_ff, cnt_tri_ff;
   logic [49:0]        prod_ff;
   logic [FW-1:0]      rr_ff;
   logic [NW-1:0]      numsh_ff;
   logic [16:0]        rq_ff;

   // window
   logic [FW-1:0] fill_ff, ones_ff;
   logic [HW-1:0] head_ff;
   logic          wbit_mem [WINDOW];
   logic          wbit_rd_ff;

   // chain memory
   mem_ctl_type    mctl;
   logic [AW-1:0]  maddr;
   chain_word_type mwdata, entry;

   logic req_fire;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   mpa_chain_mem #(.CHAINS(CHAINS), .AW(AW)) u_mem (
      .clock (clock),
      .reset (reset),
      .ctl   (mctl),
      .addr  (maddr),
      .wdata (mwdata),
      .rdata (entry)
   );

   // trial update values
   logic [31:0] tri_in, accs_in;
   always_comb begin
      tri_in  = (entry.trials == 32'hFFFF_FFFF) ? entry.trials : entry.trials + 32'd1;
      accs_in = entry.accepts;
      if (ok_ff && entry.accepts != 32'hFFFF_FFFF) begin
         accs_in = entry.accepts + 32'd1;
      end
      mwdata.trials     = tri_in;
      mwdata.accepts    = accs_in;
      mwdata.last_value = ok_ff ? trial_ff : entry.last_value;
   end

   always_comb begin
      mctl.rd  = req_fire;
      mctl.wr  = (state_ff == S_UPDATE);
      mctl.clr = (state_ff == S_READ) && (act_ff == ACT_CLEAR);
      maddr    = req_fire ? AW'(req_chain) : idx_ff;
   end

   // window bit memory: read at head on item start, written at head on update
   always_ff @(posedge clock) begin
      if (state_ff == S_UPDATE) begin
         wbit_mem[head_ff] <= ok_ff;
      end
      if (req_fire) begin
         wbit_rd_ff <= wbit_mem[head_ff];
      end
   end

   // combinational steps
   logic [64:0] r2;
   logic        r2_ge;
   logic [63:0] mul_full;
   logic [32:0] mul_rnd;
   logic [16:0] p16;
   logic [FW:0] rr2;
   logic        rr2_ge;
   logic signed [18:0] rate_s, hi_s, lo_s;
   logic [18:0] factor;
   logic [50:0] t_rnd;
   logic [31:0] t_sat;
   logic [FW-1:0] ones_in;
   logic [HW-1:0] head_in;

   always_comb begin
      r2       = {rem_ff, 1'b0};
      r2_ge    = (r2 >= {1'b0, p_ff});
      mul_full = acc_ff[31:0] * exp_bit(expb_ff);
      mul_rnd  = 33'((65'(mul_full) + 65'(64'h8000_0000)) >> 32);
      p16      = 17'((34'(acc_ff) + 34'(16'h8000)) >> 16);
      rr2      = {rr_ff, numsh_ff[NW-1]};
      rr2_ge   = (rr2 >= {1'b0, fill_ff});
      rate_s   = signed'({2'b00, rq_ff});
      hi_s     = signed'(19'(target_ff) + 19'(band_ff));
      lo_s     = signed'(19'(target_ff) - 19'(band_ff));
      factor   = 19'(131072) + 19'(target_ff) - 19'(rq_ff);
      t_rnd    = (51'(prod_ff) + 51'(32'h0001_0000)) >> 17;
      if (t_rnd > 51'(32'hFFFF_FFFF)) begin
         t_sat = 32'hFFFF_FFFF;
      end else if (t_rnd == 51'd0) begin
         t_sat = 32'd1;
      end else begin
         t_sat = t_rnd[31:0];
      end
      // oldest bit leaves only once the window is full
      ones_in = ones_ff + FW'(ok_ff);
      if (fill_ff == FW'(WINDOW)) begin
         ones_in = ones_in - FW'(wbit_rd_ff);
      end
      head_in = (head_ff == HW'(WINDOW - 1)) ? '0 : head_ff + HW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_valid  <= 1'b0;
         scale_ff   <= SCALE_RESET;
         temp_ff    <= TEMP_RESET;
         target_ff  <= TARGET_RESET;
         band_ff    <= BAND_RESET;
         fill_ff    <= '0;
         ones_ff    <= '0;
         head_ff    <= '0;
      end else begin
         if (rsp_valid && rsp_ready && state_ff != S_FINISH) begin
            rsp_valid <= 1'b0;
         end
         if (csr_write_enable) begin
            case (reg_index_type'(csr_index))
               REG_INIT_TEMP: temp_ff   <= (csr_write_data == 32'd0) ? 32'd1 : csr_write_data;
               REG_SCALE:     scale_ff  <= csr_write_data;
               REG_TARGET:    target_ff <= csr_write_data[15:0];
               REG_BAND:      band_ff   <= csr_write_data[15:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  act_ff      <= action_type'(req_action);
                  chain_ok_ff <= (32'(req_chain) < CHAINS);
                  idx_ff      <= AW'(req_chain);
                  trial_ff    <= req_trial_value;
                  rnd_ff      <= req_random_fraction;
                  ok_ff       <= 1'b0;
                  ann_ff      <= 1'b0;
                  state_ff    <= S_READ;
               end
            end
            S_READ: begin
               d_ff       <= 33'(trial_ff) - 33'(signed'(entry.last_value));
               p_ff       <= scale_ff * temp_ff;
               // clear reports zero counts
               cnt_acc_ff <= (chain_ok_ff && act_ff != ACT_CLEAR) ? entry.accepts : 32'd0;
               cnt_tri_ff <= (chain_ok_ff && act_ff != ACT_CLEAR) ? entry.trials : 32'd0;
               rr_ff      <= '0;
               numsh_ff   <= {ones_ff, 16'd0};
               cnt_ff     <= CNT_W'(NW);
               case (act_ff)
                  ACT_TRIAL:  state_ff <= chain_ok_ff ? S_CHECK : S_FINISH;
                  ACT_ANNEAL: state_ff <= (fill_ff == '0) ? S_FINISH : S_RDIV;
                  ACT_CLEAR: begin
                     fill_ff    <= '0;
                     ones_ff    <= '0;
                     head_ff    <= '0;
                     state_ff   <= S_FINISH;
                  end
                  default: state_ff <= S_FINISH;
               endcase
            end
            S_CHECK: begin
               rem_ff <= 64'({d_ff[31:0], 12'd0});
               cnt_ff <= CNT_W'(EXP_BITS);
               if (d_ff <= 33'sd0) begin
                  ok_ff    <= 1'b1;
                  state_ff <= S_UPDATE;
               end else if (p_ff == 64'd0 || 64'({d_ff[31:0], 12'd0}) >= p_ff) begin
                  // x of 16.0 or more: probability zero
                  state_ff <= S_UPDATE;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff  <= r2_ge ? 64'(r2 - {1'b0, p_ff}) : r2[63:0];
               quot_ff <= {quot_ff[18:0], r2_ge};
               cnt_ff  <= cnt_ff - CNT_W'(1);
               expb_ff <= '0;
               acc_ff  <= 33'h1_0000_0000;
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= S_EXP;
               end
            end
            S_EXP: begin
               if (quot_ff[expb_ff]) begin
                  acc_ff <= acc_ff[32] ? 33'(exp_bit(expb_ff)) : mul_rnd;
               end
               expb_ff <= expb_ff + 5'd1;
               if (expb_ff == 5'(EXP_BITS - 1)) begin
                  state_ff <= S_PROB;
               end
            end
            S_PROB: begin
               ok_ff    <= ({1'b0, rnd_ff} < p16);
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               cnt_acc_ff <= accs_in;
               cnt_tri_ff <= tri_in;
               if (fill_ff != FW'(WINDOW)) begin
                  fill_ff <= fill_ff + FW'(1);
               end
               ones_ff  <= ones_in;
               head_ff  <= head_in;
               state_ff <= S_FINISH;
            end
            S_RDIV: begin
               rr_ff    <= rr2_ge ? FW'(rr2 - {1'b0, fill_ff}) : rr2[FW-1:0];
               rq_ff    <= {rq_ff[15:0], rr2_ge};
               numsh_ff <= numsh_ff << 1;
               cnt_ff   <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= S_ANN;
               end
            end
            S_ANN: begin
               prod_ff <= temp_ff * factor[17:0];
               state_ff <= (rate_s > hi_s || rate_s < lo_s) ? S_ANN2 : S_FINISH;
            end
            S_ANN2: begin
               temp_ff  <= t_sat;
               ann_ff   <= 1'b1;
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (!rsp_valid || rsp_ready) begin
                  rsp_valid           <= 1'b1;
                  rsp_accepted        <= ok_ff;
                  rsp_annealed        <= ann_ff;
                  rsp_accept_count    <= cnt_acc_ff;
                  rsp_trial_count     <= cnt_tri_ff;
                  rsp_temperature_now <= temp_ff;
                  state_ff            <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[src/mpa_chain_mem.sv]
// ----------------------------------------------------------------------------
// mpa_chain_mem: per-chain state memory
// One word per chain, registered read, valid bits give reset value.
// ----------------------------------------------------------------------------
module mpa_chain_mem #(
   parameter int CHAINS = mpa_pkg::CHAINS_DEFAULT,
   parameter int AW     = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mpa_pkg::mem_ctl_type    ctl,
   input  logic [AW-1:0]           addr,
   input  mpa_pkg::chain_word_type wdata,
   output mpa_pkg::chain_word_type rdata
);
   import mpa_pkg::*;

   chain_word_type mem [CHAINS];
   chain_word_type rd_ff;
   logic [CHAINS-1:0] vld_ff;
   logic rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clr) begin
         vld_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr) begin
            vld_ff[addr] <= 1'b1;
         end
         if (ctl.rd) begin
            rd_vld_ff <= vld_ff[addr];
         end
      end
   end

   assign rdata = rd_vld_ff ? rd_ff : CHAIN_RESET;

endmodule
